/* sv/lavm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the look-at view matrix pipeline.
// No dependencies; imported by the normalize, square-root and divide units.
package lavm_pkg;

    localparam int SCALE_W    = 30;   // normalized magnitude width, top bit in [2^29, 2^30)
    localparam int SUMSQ_W    = 62;   // sum of three squared magnitudes
    localparam int ROOT_W     = 31;   // floor square root of the sum
    localparam int ROOT_STEPS = 32;   // one root bit per stage

    typedef logic [SCALE_W-1:0] scaled_t;
    typedef logic [ROOT_W-1:0]  root_t;

endpackage

/* sv/lavm_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on lavm_pkg; carries a side tag in step with each word.
module lavm_isqrt
    import lavm_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  logic [SUMSQ_W-1:0]  sq_in,
    input  logic [TAG_W-1:0]    tag_in,
    output logic                vld_out,
    output root_t               root_out,
    output logic [TAG_W-1:0]    tag_out
);

    localparam int RW = SUMSQ_W + 2;

    logic [ROOT_STEPS:0] vld_reg;
    logic [SUMSQ_W-1:0]  rem_reg [0:ROOT_STEPS];
    logic [RW-1:0]       rt_reg  [0:ROOT_STEPS];
    logic [TAG_W-1:0]    tag_reg [0:ROOT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_STEPS-1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= sq_in;
        rt_reg[0]  <= '0;
        tag_reg[0] <= tag_in;
    end

    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_STEPS - 1 - j));
        logic [RW-1:0] trial;
        logic          take;

        assign trial = rt_reg[j] + BIT;
        assign take  = {2'b00, rem_reg[j]} >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= take ? SUMSQ_W'({2'b00, rem_reg[j]} - trial) : rem_reg[j];
            rt_reg[j+1]  <= take ? (rt_reg[j] >> 1) + BIT : rt_reg[j] >> 1;
            tag_reg[j+1] <= tag_reg[j];
        end
    end

    assign vld_out  = vld_reg[ROOT_STEPS];
    assign root_out = rt_reg[ROOT_STEPS][ROOT_W-1:0];
    assign tag_out  = tag_reg[ROOT_STEPS];

endmodule

/* sv/lavm_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor: rounded mag/len.
// Depends on lavm_pkg; carries a side tag in step with each word.
module lavm_div
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  scaled_t              mag_in [3],
    input  root_t                len_in,
    input  logic [TAG_W-1:0]     tag_in,
    output logic                 vld_out,
    output logic [FRAC_BITS:0]   quot_out [3],
    output logic [TAG_W-1:0]     tag_out
);

    localparam int NW    = SCALE_W + FRAC_BITS + 1;
    localparam int STEPS = FRAC_BITS + 1;

    logic [STEPS:0]      vld_reg;
    logic [NW-1:0]       num_reg [0:STEPS][3];
    logic [ROOT_W-1:0]   rem_reg [0:STEPS][3];
    logic [FRAC_BITS:0]  q_reg   [0:STEPS][3];
    root_t               len_reg [0:STEPS];
    logic [TAG_W-1:0]    tag_reg [0:STEPS];
    logic [NW-1:0]       num_in  [3];

    // numerator carries half the divisor for round-to-nearest
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_in[i] = {1'b0, mag_in[i], {FRAC_BITS{1'b0}}} + NW'(len_in >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STEPS-1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[0][i] <= num_in[i];
            rem_reg[0][i] <= ROOT_W'(num_in[i] >> STEPS);
            q_reg[0][i]   <= '0;
        end
        len_reg[0] <= len_in;
        tag_reg[0] <= tag_in;
    end

    for (genvar t = 0; t < STEPS; t++)
    begin : g_step
        localparam int B = FRAC_BITS - t;
        logic [ROOT_W:0] sh   [3];
        logic            take [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh[i]   = {rem_reg[t][i], num_reg[t][i][B]};
                take[i] = sh[i] >= {1'b0, len_reg[t]};
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[t+1][i] <= num_reg[t][i];
                rem_reg[t+1][i] <= take[i] ? ROOT_W'(sh[i] - {1'b0, len_reg[t]})
                                           : ROOT_W'(sh[i]);
                q_reg[t+1][i]   <= {q_reg[t][i][FRAC_BITS-1:0], take[i]};
            end
            len_reg[t+1] <= len_reg[t];
            tag_reg[t+1] <= tag_reg[t];
        end
    end

    assign vld_out = vld_reg[STEPS];
    assign tag_out = tag_reg[STEPS];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot_out[i] = q_reg[STEPS][i];
        end
    end

endmodule

/* sv/lavm_norm.sv */
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: block shift, sum of squares, root, divide.
// Depends on lavm_pkg, lavm_isqrt and lavm_div.
module lavm_norm
    import lavm_pkg::*;
#(
    parameter int VW        = 33,
    parameter int WW        = 33,
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vld_in,
    input  logic signed [VW-1:0]        val_in [3],
    input  logic [TAG_W-1:0]            tag_in,
    output logic                        vld_out,
    output logic signed [FRAC_BITS+1:0] unit_out [3],
    output logic [TAG_W-1:0]            tag_out
);

    localparam int K   = $clog2(WW);
    localparam int AW  = FRAC_BITS + 2;
    localparam int DT  = 4 + TAG_W;
    localparam int RT  = 3 * SCALE_W + DT;

    logic [K:0]          sh_vld_reg;
    logic [WW-1:0]       mag_reg  [0:K][3];
    logic [2:0]          sgn_reg  [0:K];
    logic                zero_reg [0:K];
    logic [TAG_W-1:0]    stag_reg [0:K];
    logic [VW-1:0]       mag_in   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = val_in[i][VW-1] ? (~val_in[i] + 1'b1) : val_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_vld_reg <= '0;
        end
        else
        begin
            sh_vld_reg <= {sh_vld_reg[K-1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[0][i] <= WW'(mag_in[i]);
            sgn_reg[0][i] <= val_in[i][VW-1];
        end
        zero_reg[0] <= (mag_in[0] | mag_in[1] | mag_in[2]) == '0;
        stag_reg[0] <= tag_in;
    end

    // left-justify all three together, halving the shift step each stage
    for (genvar s = 0; s < K; s++)
    begin : g_shift
        localparam int SH = 1 << (K - 1 - s);
        logic [WW-1:0] orv;
        logic          hit;

        assign orv = mag_reg[s][0] | mag_reg[s][1] | mag_reg[s][2];
        assign hit = orv[WW-1 -: SH] == '0;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[s+1][i] <= hit ? mag_reg[s][i] << SH : mag_reg[s][i];
            end
            sgn_reg[s+1]  <= sgn_reg[s];
            zero_reg[s+1] <= zero_reg[s];
            stag_reg[s+1] <= stag_reg[s];
        end
    end

    scaled_t                top_m     [3];
    logic                   sq_vld_reg;
    logic [2*SCALE_W-1:0]   sq_reg    [3];
    scaled_t                sq_m_reg  [3];
    logic [2:0]             sq_sgn_reg;
    logic                   sq_zero_reg;
    logic [TAG_W-1:0]       sq_tag_reg;
    logic                   su_vld_reg;
    logic [SUMSQ_W-1:0]     su_sum_reg;
    scaled_t                su_m_reg  [3];
    logic [2:0]             su_sgn_reg;
    logic                   su_zero_reg;
    logic [TAG_W-1:0]       su_tag_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            top_m[i] = mag_reg[K][i][WW-1 -: SCALE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            su_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= sh_vld_reg[K];
            su_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i]   <= top_m[i] * top_m[i];
            sq_m_reg[i] <= top_m[i];
            su_m_reg[i] <= sq_m_reg[i];
        end
        sq_sgn_reg  <= sgn_reg[K];
        sq_zero_reg <= zero_reg[K];
        sq_tag_reg  <= stag_reg[K];
        su_sum_reg  <= SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[1]) + SUMSQ_W'(sq_reg[2]);
        su_sgn_reg  <= sq_sgn_reg;
        su_zero_reg <= sq_zero_reg;
        su_tag_reg  <= sq_tag_reg;
    end

    logic               rt_vld;
    root_t              rt_len;
    logic [RT-1:0]      rt_tag;
    scaled_t            rt_m [3];

    lavm_isqrt #(
        .TAG_W (RT)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (su_vld_reg),
        .sq_in    (su_sum_reg),
        .tag_in   ({su_m_reg[0], su_m_reg[1], su_m_reg[2], su_sgn_reg, su_zero_reg,
                    su_tag_reg}),
        .vld_out  (rt_vld),
        .root_out (rt_len),
        .tag_out  (rt_tag)
    );

    assign rt_m[0] = rt_tag[RT-1 -: SCALE_W];
    assign rt_m[1] = rt_tag[RT-1-SCALE_W -: SCALE_W];
    assign rt_m[2] = rt_tag[RT-1-2*SCALE_W -: SCALE_W];

    logic                dv_vld;
    logic [FRAC_BITS:0]  dv_q [3];
    logic [DT-1:0]       dv_tag;

    lavm_div #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (DT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (rt_vld),
        .mag_in   (rt_m),
        .len_in   (rt_len),
        .tag_in   (rt_tag[DT-1:0]),
        .vld_out  (dv_vld),
        .quot_out (dv_q),
        .tag_out  (dv_tag)
    );

    logic                out_vld_reg;
    logic signed [AW-1:0] unit_reg [3];
    logic [TAG_W-1:0]    out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= dv_vld;
        end
    end

    // zero-length input: drop the quotient, emit the zero vector
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_tag[TAG_W])
            begin
                unit_reg[i] <= '0;
            end
            else if (dv_tag[TAG_W+1+i])
            begin
                unit_reg[i] <= -AW'(dv_q[i]);
            end
            else
            begin
                unit_reg[i] <= AW'(dv_q[i]);
            end
        end
        out_tag_reg <= dv_tag[TAG_W-1:0];
    end

    assign vld_out = out_vld_reg;
    assign tag_out = out_tag_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unit_out[i] = unit_reg[i];
        end
    end

endmodule

/* sv/look_at_view_matrix.sv */
`timescale 1ns / 1ps
// Look-at view matrix: back, side and up axes plus translation column.
// Depends on lavm_pkg (via submodules) and lavm_norm.
//
// Usage: drive eye, aim and sky (signed Q16.16 by default) and pulse start.
// A word is taken at every edge where start is high; busy stays low, so a
// new word may enter every cycle and many words are in flight at once.
// Each result shows for one cycle with done high; the receiver cannot stall
// it, and results leave in the order the words came in.
// Each normalizer works at a width of at least 30 bits.
// The depth is set by the three normalizers: a 32-stage square root and a
// FRAC_BITS+1 stage divider each; two of them run side by side.
// Throughput: one matrix per clock.
// Reset empties the pipeline: all valid bits clear, no done is raised for
// words that were in flight.
module look_at_view_matrix #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic signed [DATA_WIDTH-1:0] eye_x,
    input  logic signed [DATA_WIDTH-1:0] eye_y,
    input  logic signed [DATA_WIDTH-1:0] eye_z,
    input  logic signed [DATA_WIDTH-1:0] aim_x,
    input  logic signed [DATA_WIDTH-1:0] aim_y,
    input  logic signed [DATA_WIDTH-1:0] aim_z,
    input  logic signed [DATA_WIDTH-1:0] sky_x,
    input  logic signed [DATA_WIDTH-1:0] sky_y,
    input  logic signed [DATA_WIDTH-1:0] sky_z,
    output logic signed [FRAC_BITS+1:0]  side_x,
    output logic signed [FRAC_BITS+1:0]  side_y,
    output logic signed [FRAC_BITS+1:0]  side_z,
    output logic signed [FRAC_BITS+1:0]  upward_x,
    output logic signed [FRAC_BITS+1:0]  upward_y,
    output logic signed [FRAC_BITS+1:0]  upward_z,
    output logic signed [FRAC_BITS+1:0]  back_x,
    output logic signed [FRAC_BITS+1:0]  back_y,
    output logic signed [FRAC_BITS+1:0]  back_z,
    output logic signed [DATA_WIDTH-1:0] shift_x,
    output logic signed [DATA_WIDTH-1:0] shift_y,
    output logic signed [DATA_WIDTH-1:0] shift_z
);

    localparam int DW   = DATA_WIDTH;
    localparam int AW   = FRAC_BITS + 2;
    localparam int PW   = 2 * AW;
    localparam int CW   = PW + 1;
    localparam int EPW  = AW + DW;
    localparam int DSW  = EPW + 2;
    localparam int TW   = DSW - FRAC_BITS + 1;
    localparam int WW1  = (DW + 1 > 30) ? DW + 1 : 30;
    localparam int WW3  = (CW > 30) ? CW : 30;
    localparam int ETAG = 3 * DW;
    localparam int BTAG = 3 * AW + 3 * DW;

    localparam logic signed [AW-1:0]  AX_ONE  = AW'(1) << FRAC_BITS;
    localparam logic signed [DSW-1:0] HALF_D  = DSW'(1) << (FRAC_BITS - 1);
    localparam logic signed [TW-1:0]  SAT_HI  = {{(TW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [TW-1:0]  SAT_LO  = {{(TW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // round half away from zero to FRAC_BITS, clamp to one
    function automatic logic signed [AW-1:0] round_away(input logic signed [CW-1:0] v);
        logic [CW-1:0]           mag;
        logic [CW-1:0]           rnd;
        logic [CW-FRAC_BITS-1:0] q;
        mag = v[CW-1] ? (~v + 1'b1) : v;
        rnd = mag + (CW'(1) << (FRAC_BITS - 1));
        q   = rnd[CW-1:FRAC_BITS];
        if (q > ((CW-FRAC_BITS)'(1) << FRAC_BITS))
        begin
            q = (CW-FRAC_BITS)'(1) << FRAC_BITS;
        end
        return v[CW-1] ? -AW'(q) : AW'(q);
    endfunction

    // floor to FRAC_BITS, negate, saturate to the data range
    function automatic logic signed [DW-1:0] neg_sat(input logic signed [DSW-1:0] s);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] n;
        t = TW'(s >>> FRAC_BITS);
        n = -t;
        if (n > SAT_HI)
        begin
            return SAT_HI[DW-1:0];
        end
        else if (n < SAT_LO)
        begin
            return SAT_LO[DW-1:0];
        end
        return n[DW-1:0];
    endfunction

    assign busy = 1'b0;

    // input stage
    logic                 in_vld_reg;
    logic signed [DW-1:0] eye_reg [3];
    logic signed [DW:0]   dif_reg [3];
    logic signed [DW-1:0] sky_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg[0] <= eye_x;
        eye_reg[1] <= eye_y;
        eye_reg[2] <= eye_z;
        dif_reg[0] <= $signed({eye_x[DW-1], eye_x}) - $signed({aim_x[DW-1], aim_x});
        dif_reg[1] <= $signed({eye_y[DW-1], eye_y}) - $signed({aim_y[DW-1], aim_y});
        dif_reg[2] <= $signed({eye_z[DW-1], eye_z}) - $signed({aim_z[DW-1], aim_z});
        sky_reg[0] <= sky_x;
        sky_reg[1] <= sky_y;
        sky_reg[2] <= sky_z;
    end

    // back axis and normalized sky, side by side with equal depth
    logic                 n1_vld;
    logic signed [AW-1:0] n1_bk [3];
    logic [ETAG-1:0]      n1_tag;
    logic signed [DW-1:0] n1_eye [3];
    logic signed [AW-1:0] n2_un [3];

    lavm_norm #(
        .VW        (DW + 1),
        .WW        (WW1),
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (ETAG)
    ) u_norm_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (in_vld_reg),
        .val_in   (dif_reg),
        .tag_in   ({eye_reg[0], eye_reg[1], eye_reg[2]}),
        .vld_out  (n1_vld),
        .unit_out (n1_bk),
        .tag_out  (n1_tag)
    );

    lavm_norm #(
        .VW        (DW),
        .WW        (WW1),
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (1)
    ) u_norm_sky (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (in_vld_reg),
        .val_in   (sky_reg),
        .tag_in   (1'b0),
        .vld_out  (),
        .unit_out (n2_un),
        .tag_out  ()
    );

    assign n1_eye[0] = n1_tag[ETAG-1 -: DW];
    assign n1_eye[1] = n1_tag[ETAG-1-DW -: DW];
    assign n1_eye[2] = n1_tag[DW-1:0];

    // cross(un, back): products, then differences
    logic                 c1_vld_reg;
    logic signed [PW-1:0] c1_p_reg   [6];
    logic signed [AW-1:0] c1_bk_reg  [3];
    logic signed [DW-1:0] c1_eye_reg [3];
    logic                 c2_vld_reg;
    logic signed [CW-1:0] c2_cr_reg  [3];
    logic signed [AW-1:0] c2_bk_reg  [3];
    logic signed [DW-1:0] c2_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else
        begin
            c1_vld_reg <= n1_vld;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_p_reg[0] <= n2_un[1] * n1_bk[2];
        c1_p_reg[1] <= n2_un[2] * n1_bk[1];
        c1_p_reg[2] <= n2_un[2] * n1_bk[0];
        c1_p_reg[3] <= n2_un[0] * n1_bk[2];
        c1_p_reg[4] <= n2_un[0] * n1_bk[1];
        c1_p_reg[5] <= n2_un[1] * n1_bk[0];
        for (int i = 0; i < 3; i++)
        begin
            c1_bk_reg[i]  <= n1_bk[i];
            c1_eye_reg[i] <= n1_eye[i];
            c2_cr_reg[i]  <= CW'(c1_p_reg[2*i]) - CW'(c1_p_reg[2*i+1]);
            c2_bk_reg[i]  <= c1_bk_reg[i];
            c2_eye_reg[i] <= c1_eye_reg[i];
        end
    end

    // side axis
    logic                 n3_vld;
    logic signed [AW-1:0] n3_sd  [3];
    logic [BTAG-1:0]      n3_tag;
    logic signed [AW-1:0] n3_bk  [3];
    logic signed [DW-1:0] n3_eye [3];

    lavm_norm #(
        .VW        (CW),
        .WW        (WW3),
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (BTAG)
    ) u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (c2_vld_reg),
        .val_in   (c2_cr_reg),
        .tag_in   ({c2_bk_reg[0], c2_bk_reg[1], c2_bk_reg[2],
                    c2_eye_reg[0], c2_eye_reg[1], c2_eye_reg[2]}),
        .vld_out  (n3_vld),
        .unit_out (n3_sd),
        .tag_out  (n3_tag)
    );

    assign n3_bk[0]  = n3_tag[BTAG-1 -: AW];
    assign n3_bk[1]  = n3_tag[BTAG-1-AW -: AW];
    assign n3_bk[2]  = n3_tag[BTAG-1-2*AW -: AW];
    assign n3_eye[0] = n3_tag[ETAG-1 -: DW];
    assign n3_eye[1] = n3_tag[ETAG-1-DW -: DW];
    assign n3_eye[2] = n3_tag[DW-1:0];

    // up axis and translation column
    logic                  d1_vld_reg;
    logic signed [PW-1:0]  d1_bs_reg  [6];
    logic signed [EPW-1:0] d1_pes_reg [3];
    logic signed [EPW-1:0] d1_peb_reg [3];
    logic signed [AW-1:0]  d1_sd_reg  [3];
    logic signed [AW-1:0]  d1_bk_reg  [3];
    logic signed [DW-1:0]  d1_eye_reg [3];

    logic                  d2_vld_reg;
    logic signed [AW-1:0]  d2_up_reg  [3];
    logic signed [DSW-1:0] d2_ds_reg;
    logic signed [DSW-1:0] d2_db_reg;
    logic signed [AW-1:0]  d2_sd_reg  [3];
    logic signed [AW-1:0]  d2_bk_reg  [3];
    logic signed [DW-1:0]  d2_eye_reg [3];

    logic                  d3_vld_reg;
    logic signed [EPW-1:0] d3_pu_reg  [3];
    logic signed [DW-1:0]  d3_ts_reg;
    logic signed [DW-1:0]  d3_tb_reg;
    logic signed [AW-1:0]  d3_up_reg  [3];
    logic signed [AW-1:0]  d3_sd_reg  [3];
    logic signed [AW-1:0]  d3_bk_reg  [3];

    logic                  d4_vld_reg;
    logic signed [DSW-1:0] d4_du_reg;
    logic signed [DW-1:0]  d4_ts_reg;
    logic signed [DW-1:0]  d4_tb_reg;
    logic signed [AW-1:0]  d4_up_reg  [3];
    logic signed [AW-1:0]  d4_sd_reg  [3];
    logic signed [AW-1:0]  d4_bk_reg  [3];

    logic                  done_reg;
    logic signed [AW-1:0]  side_reg   [3];
    logic signed [AW-1:0]  upward_reg [3];
    logic signed [AW-1:0]  back_reg   [3];
    logic signed [DW-1:0]  shift_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            d4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            d1_vld_reg <= n3_vld;
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            d4_vld_reg <= d3_vld_reg;
            done_reg   <= d4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_bs_reg[0] <= n3_bk[1] * n3_sd[2];
        d1_bs_reg[1] <= n3_bk[2] * n3_sd[1];
        d1_bs_reg[2] <= n3_bk[2] * n3_sd[0];
        d1_bs_reg[3] <= n3_bk[0] * n3_sd[2];
        d1_bs_reg[4] <= n3_bk[0] * n3_sd[1];
        d1_bs_reg[5] <= n3_bk[1] * n3_sd[0];
        for (int i = 0; i < 3; i++)
        begin
            d1_pes_reg[i] <= n3_sd[i] * n3_eye[i];
            d1_peb_reg[i] <= n3_bk[i] * n3_eye[i];
            d1_sd_reg[i]  <= n3_sd[i];
            d1_bk_reg[i]  <= n3_bk[i];
            d1_eye_reg[i] <= n3_eye[i];

            d2_up_reg[i]  <= round_away(CW'(d1_bs_reg[2*i]) - CW'(d1_bs_reg[2*i+1]));
            d2_sd_reg[i]  <= d1_sd_reg[i];
            d2_bk_reg[i]  <= d1_bk_reg[i];
            d2_eye_reg[i] <= d1_eye_reg[i];

            d3_pu_reg[i]  <= d2_up_reg[i] * d2_eye_reg[i];
            d3_up_reg[i]  <= d2_up_reg[i];
            d3_sd_reg[i]  <= d2_sd_reg[i];
            d3_bk_reg[i]  <= d2_bk_reg[i];

            d4_up_reg[i]  <= d3_up_reg[i];
            d4_sd_reg[i]  <= d3_sd_reg[i];
            d4_bk_reg[i]  <= d3_bk_reg[i];

            side_reg[i]   <= d4_sd_reg[i];
            upward_reg[i] <= d4_up_reg[i];
            back_reg[i]   <= d4_bk_reg[i];
        end
        d2_ds_reg <= DSW'(d1_pes_reg[0]) + DSW'(d1_pes_reg[1]) + DSW'(d1_pes_reg[2]) + HALF_D;
        d2_db_reg <= DSW'(d1_peb_reg[0]) + DSW'(d1_peb_reg[1]) + DSW'(d1_peb_reg[2]) + HALF_D;
        d3_ts_reg <= neg_sat(d2_ds_reg);
        d3_tb_reg <= neg_sat(d2_db_reg);
        d4_du_reg <= DSW'(d3_pu_reg[0]) + DSW'(d3_pu_reg[1]) + DSW'(d3_pu_reg[2]) + HALF_D;
        d4_ts_reg <= d3_ts_reg;
        d4_tb_reg <= d3_tb_reg;
        shift_reg[0] <= d4_ts_reg;
        shift_reg[1] <= neg_sat(d4_du_reg);
        shift_reg[2] <= d4_tb_reg;
    end

    assign done     = done_reg;
    assign side_x   = side_reg[0];
    assign side_y   = side_reg[1];
    assign side_z   = side_reg[2];
    assign upward_x = upward_reg[0];
    assign upward_y = upward_reg[1];
    assign upward_z = upward_reg[2];
    assign back_x   = back_reg[0];
    assign back_y   = back_reg[1];
    assign back_z   = back_reg[2];
    assign shift_x  = shift_reg[0];
    assign shift_y  = shift_reg[1];
    assign shift_z  = shift_reg[2];

    a_side_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (side_x <= AX_ONE && side_x >= -AX_ONE &&
                  back_z <= AX_ONE && back_z >= -AX_ONE))
        else $error("axis component outside [-1, 1]");

    a_up_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (upward_x <= AX_ONE && upward_x >= -AX_ONE &&
                  upward_y <= AX_ONE && upward_y >= -AX_ONE))
        else $error("up component outside [-1, 1]");

    a_tail_flow: assert property (@(posedge clk) disable iff (!rst_n)
        n3_vld |=> d1_vld_reg ##4 done)
        else $error("word lost in translation stages");

endmodule
